// ----- design/error_text_keyword_classifier_defines.svh -----
// Assertion macros used by the keyword classifier top level.
`ifndef ERROR_TEXT_KEYWORD_CLASSIFIER_DEFINES_SVH
`define ERROR_TEXT_KEYWORD_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EKC_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("keyword classifier check failed");

// Next-cycle implication, checked outside reset.
`define EKC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("keyword classifier check failed");

`endif

// ----- design/ekc_pkg.sv -----
// Package with keyword tables, category codes and shared types of the classifier.
`default_nettype none
package ekc_pkg;

  localparam int NUM_KW          = 17;
  localparam int LONGEST_KEYWORD = 12;
  localparam int WIN_DEPTH       = LONGEST_KEYWORD - 1;
  localparam int KW_MAXLEN       = 12;
  localparam int OFS_W           = $clog2(LONGEST_KEYWORD);

  // Keywords right-justified: the last character sits in bits [7:0].
  localparam logic [KW_MAXLEN*8-1:0] KW_STR [NUM_KW] = '{
    "timeout", "timed out", "deadline", "unauthorized", "forbidden", "auth",
    "not found", "404", "rate limit", "429", "too many", "500", "internal",
    "server error", "invalid", "bad request", "400"
  };

  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd7, 4'd9, 4'd8, 4'd12, 4'd9, 4'd4, 4'd9, 4'd3, 4'd10, 4'd3, 4'd8,
    4'd3, 4'd8, 4'd12, 4'd7, 4'd11, 4'd3
  };

  localparam logic [2:0] CAT_NONE          = 3'd0;
  localparam logic [2:0] CAT_TIMEOUT       = 3'd1;
  localparam logic [2:0] CAT_AUTH          = 3'd2;
  localparam logic [2:0] CAT_NOT_FOUND     = 3'd3;
  localparam logic [2:0] CAT_RATE_LIMITED  = 3'd4;
  localparam logic [2:0] CAT_SERVER        = 3'd5;
  localparam logic [2:0] CAT_INVALID_INPUT = 3'd6;
  localparam logic [2:0] CAT_TRANSIENT     = 3'd7;

  localparam logic [12:0] DELAY_NONE  = 13'd0;
  localparam logic [12:0] DELAY_SHORT = 13'd1000;
  localparam logic [12:0] DELAY_MID   = 13'd2000;
  localparam logic [12:0] DELAY_LONG  = 13'd5000;

  typedef struct packed {
    logic shift;
    logic clear;
  } ekc_cell_ctl_t;

  typedef struct packed {
    logic [12:0] backoff_ms;
    logic        retryable;
    logic [2:0]  category;
  } ekc_result_t;

  // One bit per keyword: set when byte b agrees with the keyword character
  // that lies ofs places before its end, or when the keyword is shorter.
  function automatic logic [NUM_KW-1:0] kw_hit_mask(input logic [7:0] b,
                                                     input logic [OFS_W-1:0] ofs);
    logic [NUM_KW-1:0] m;
    m = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (int'(ofs) >= int'(KW_LEN[k]) || int'(ofs) >= KW_MAXLEN) begin
        m[k] = 1'b1;
      end else begin
        m[k] = (b == KW_STR[k][8*int'(ofs) +: 8]);
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- design/ekc_cell.sv -----
// One window cell: holds a past byte, passes it on, and reports keyword hits.
`default_nettype none
module ekc_cell
  import ekc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ekc_cell_ctl_t       ctl,
  input  wire logic [OFS_W-1:0]    ofs,
  input  wire logic [7:0]          d_in,
  output logic      [7:0]          q,
  output logic      [NUM_KW-1:0]   hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctl.shift) begin
      byte_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  assign q   = byte_r;
  assign hit = kw_hit_mask(byte_r, ofs);

endmodule
`default_nettype wire

// ----- design/ekc_class.sv -----
// Priority encoder from the sticky keyword flags to category, retry flag and delay.
`default_nettype none
module ekc_class
  import ekc_pkg::*;
(
  input  wire logic [NUM_KW-1:0] seen,
  output ekc_result_t            res
);

  localparam logic [NUM_KW-1:0] MASK_TIMEOUT = 17'h00007;
  localparam logic [NUM_KW-1:0] MASK_AUTH    = 17'h00038;
  localparam logic [NUM_KW-1:0] MASK_NOTFND  = 17'h000C0;
  localparam logic [NUM_KW-1:0] MASK_RATE    = 17'h00700;
  localparam logic [NUM_KW-1:0] MASK_SERVER  = 17'h03800;
  localparam logic [NUM_KW-1:0] MASK_INVALID = 17'h1C000;

  always_comb begin
    priority if ((seen & MASK_TIMEOUT) != '0) begin
      res = '{backoff_ms: DELAY_SHORT, retryable: 1'b1, category: CAT_TIMEOUT};
    end else if ((seen & MASK_AUTH) != '0) begin
      res = '{backoff_ms: DELAY_NONE, retryable: 1'b0, category: CAT_AUTH};
    end else if ((seen & MASK_NOTFND) != '0) begin
      res = '{backoff_ms: DELAY_NONE, retryable: 1'b0, category: CAT_NOT_FOUND};
    end else if ((seen & MASK_RATE) != '0) begin
      res = '{backoff_ms: DELAY_LONG, retryable: 1'b1, category: CAT_RATE_LIMITED};
    end else if ((seen & MASK_SERVER) != '0) begin
      res = '{backoff_ms: DELAY_MID, retryable: 1'b1, category: CAT_SERVER};
    end else if ((seen & MASK_INVALID) != '0) begin
      res = '{backoff_ms: DELAY_NONE, retryable: 1'b0, category: CAT_INVALID_INPUT};
    end else begin
      res = '{backoff_ms: DELAY_SHORT, retryable: 1'b1, category: CAT_TRANSIENT};
    end
  end

endmodule
`default_nettype wire

// ----- design/error_text_keyword_classifier.sv -----
// Top level of the error-text keyword classifier.
// A result is registered and appears in the cycle after its last (or empty) item.
// Throughput: one item per cycle; the keyword match is a single pass over the cell row.
// A result waiting on the output only stalls items that would produce another result.
// Reset (rst_n low, synchronous) clears the byte window, the keyword flags and
// the output valid; no clearing pass is needed afterwards.
`default_nettype none
`include "error_text_keyword_classifier_defines.svh"
module error_text_keyword_classifier
  import ekc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // is_last
  input  wire logic        in_tuser,   // message_empty
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [2:0] category, [3] retryable,
                                       // [16:4] backoff_ms, [23:17] zero
);

  // Handshake. Items that end a message need a free output slot; the others
  // only move the window and can pass even while a result waits.
  logic in_fire;
  logic ends_msg;

  assign ends_msg  = in_tlast | in_tuser;
  assign in_tready = !out_tvalid || out_tready || !ends_msg;
  assign in_fire   = in_tvalid & in_tready;

  // Fold A-Z to lower case before matching and storing.
  logic [7:0] cur;
  always_comb begin
    cur = in_tdata;
    if (in_tdata >= 8'h41 && in_tdata <= 8'h5A) begin
      cur = in_tdata + 8'h20;
    end
  end

  // The window is a row of cells. Cell i holds the byte i+1 places back and
  // hands it to cell i+1 on every accepted item. A message end wipes the row.
  ekc_cell_ctl_t      cell_ctl;
  logic [7:0]         win [WIN_DEPTH];
  logic [NUM_KW-1:0]  hit [WIN_DEPTH];

  assign cell_ctl.clear = in_fire & ends_msg;
  assign cell_ctl.shift = in_fire;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    ekc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (cell_ctl),
      .ofs   (OFS_W'(i + 1)),
      .d_in  ((i == 0) ? cur : win[(i == 0) ? 0 : i - 1]),
      .q     (win[i]),
      .hit   (hit[i])
    );
  end

  // A keyword ends at the current byte when the current byte and every cell
  // agree with it.
  logic [NUM_KW-1:0] match;
  always_comb begin
    match = kw_hit_mask(cur, '0);
    for (int i = 0; i < WIN_DEPTH; i++) begin
      match = match & hit[i];
    end
  end

  // Sticky keyword flags for the message in progress.
  logic [NUM_KW-1:0] seen_r;
  logic [NUM_KW-1:0] seen_nxt;
  logic [NUM_KW-1:0] seen_now;

  assign seen_now = seen_r | match;

  always_comb begin
    seen_nxt = seen_r;
    if (in_fire) begin
      seen_nxt = ends_msg ? '0 : seen_now;
    end
  end

  // Category from the flags including the last byte's matches.
  ekc_result_t cls_res;
  ekc_class u_class (
    .seen (seen_now),
    .res  (cls_res)
  );

  // Output register.
  logic        out_valid_r;
  logic        out_valid_nxt;
  ekc_result_t out_res_r;
  ekc_result_t out_res_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (in_fire && ends_msg) begin
      out_valid_nxt = 1'b1;
      if (in_tuser) begin
        out_res_nxt = '{backoff_ms: DELAY_NONE, retryable: 1'b0, category: CAT_NONE};
      end else begin
        out_res_nxt = cls_res;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r};

  // An empty message yields category none in the next cycle.
  `EKC_ASSERT_NEXT(a_empty_none, clk, rst_n, in_fire && in_tuser,
                   out_tvalid && out_tdata[2:0] == CAT_NONE)
  // The flags start clean after every message end.
  `EKC_ASSERT_NEXT(a_flags_cleared, clk, rst_n, in_fire && ends_msg, seen_r == '0)
  // Retryable categories always carry a delay, the others never do.
  `EKC_ASSERT_NOW(a_retry_delay, clk, rst_n, out_tvalid,
                  out_tdata[3] == (out_tdata[16:4] != 13'd0))

endmodule
`default_nettype wire
